// ----- rtl/slcg_pkg.sv -----
package slcg_pkg;

    localparam int LCG_MOD = 714025;
    localparam int LCG_MUL = 1366;
    localparam int LCG_INC = 150889;

    localparam int TABLE_SIZE_DEF = 97;

    localparam int SEED_W   = 32;
    localparam int LCG_W    = 24;
    localparam int SAMPLE_W = 20;
    localparam int FRAC_W   = 24;

    // constant divider by LCG_MOD: quotient estimate from a scaled reciprocal
    localparam int DIV_IN_W  = SAMPLE_W + FRAC_W;
    localparam int DIV_LOW   = 14;
    localparam int DIV_SHIFT = 32;
    localparam int DIV_Q_W   = 24;
    localparam int DIV_R_W   = SAMPLE_W + 1;
    localparam longint unsigned RECIP = (64'd1 << (DIV_SHIFT + DIV_LOW)) / 64'(LCG_MOD);
    localparam int RECIP_W = $clog2(RECIP + 64'd1);

    typedef enum logic [1:0] {
        OP_SEED,
        OP_LCG,
        OP_SLOT,
        OP_FRAC
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_RF_MOD_GO,
        ST_RF_MOD_WAIT,
        ST_RF_STEP_GO,
        ST_RF_STEP_WAIT,
        ST_SLOT_GO,
        ST_SLOT_WAIT,
        ST_READ,
        ST_LCG_WAIT,
        ST_FRAC_GO,
        ST_FRAC_WAIT,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic load_in;
        logic seed_apply;
        logic div_start;
        t_op  div_op;
        logic rf_init;
        logic rf_step;
        logic slot_load;
        logic tbl_read;
        logic draw_commit;
        logic frac_load;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_refill;
        logic div_done;
        logic rf_last;
    } t_dp_status;

endpackage

// ----- rtl/slcg_if.sv -----
interface slcg_in_if import slcg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic signed [SEED_W-1:0] seed_value;

    modport source (output valid, cmd, seed_value, input ready);
    modport sink (input valid, cmd, seed_value, output ready);
endinterface

interface slcg_out_if import slcg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic [FRAC_W-1:0]   fraction;
    logic [SAMPLE_W-1:0] next_state;
    logic                seed_adjusted;

    modport source (output valid, sample, fraction, next_state, seed_adjusted, input ready);
    modport sink (input valid, sample, fraction, next_state, seed_adjusted, output ready);
endinterface

// ----- rtl/slcg_ram.sv -----
module slcg_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 97,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/slcg_divm.sv -----
module slcg_divm import slcg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_IN_W-1:0] i_value,
    output logic                o_done,
    output logic [DIV_Q_W-1:0]  o_quot,
    output logic [SAMPLE_W-1:0] o_rem
);

    localparam logic [RECIP_W-1:0]  RECIP_C = RECIP_W'(RECIP);
    localparam logic [SAMPLE_W-1:0] MOD_C   = SAMPLE_W'(LCG_MOD);
    localparam int PROD_W = DIV_IN_W - DIV_LOW + RECIP_W;

    logic [3:0]          r_vld;
    logic [DIV_IN_W-1:0] r_v0;
    logic [DIV_IN_W-1:0] r_v1;
    logic [DIV_Q_W-1:0]  r_q1;
    logic [DIV_Q_W-1:0]  r_q2;
    logic [DIV_Q_W-1:0]  r_q3;
    logic [DIV_R_W-1:0]  r_r2;
    logic [SAMPLE_W-1:0] r_r3;

    logic [PROD_W-1:0]   w_prod;
    logic [DIV_IN_W-1:0] w_qm;
    logic [DIV_IN_W-1:0] w_diff;

    // estimate never exceeds the true quotient and is short by at most one
    assign w_prod = r_v0[DIV_IN_W-1:DIV_LOW] * RECIP_C;
    assign w_qm   = r_q1 * MOD_C;
    assign w_diff = r_v1 - w_qm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v0 <= i_value;
        end
        r_q1 <= w_prod[DIV_SHIFT+DIV_Q_W-1:DIV_SHIFT];
        r_v1 <= r_v0;
        r_r2 <= w_diff[DIV_R_W-1:0];
        r_q2 <= r_q1;
        if (r_r2 >= DIV_R_W'(LCG_MOD)) begin
            r_r3 <= SAMPLE_W'(r_r2 - DIV_R_W'(LCG_MOD));
            r_q3 <= r_q2 + DIV_Q_W'(1);
        end else begin
            r_r3 <= r_r2[SAMPLE_W-1:0];
            r_q3 <= r_q2;
        end
    end

    assign o_done = r_vld[3];
    assign o_quot = r_q3;
    assign o_rem  = r_r3;

endmodule

// ----- rtl/slcg_datapath.sv -----
module slcg_datapath import slcg_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    input  logic                     i_in_cmd,
    input  logic signed [SEED_W-1:0] i_seed_value,
    output logic [SAMPLE_W-1:0]      o_sample,
    output logic [FRAC_W-1:0]        o_fraction,
    output logic [SAMPLE_W-1:0]      o_next_state,
    output logic                     o_seed_adjusted
);

    localparam int ADDR_W = $clog2(TABLE_SIZE);
    localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
    localparam int D_W    = LCG_W + 1;

    logic                r_cmd;
    logic [SEED_W-1:0]   r_seed;
    logic [LCG_W-1:0]    r_lcg;
    logic [SAMPLE_W-1:0] r_sv;
    logic                r_init;
    logic [D_W-1:0]      r_d;
    logic                r_adj;
    logic [CNT_W-1:0]    r_cnt;
    logic [ADDR_W-1:0]   r_slot;
    logic [SAMPLE_W-1:0] r_sample;
    logic [FRAC_W-1:0]   r_frac;
    logic [SAMPLE_W-1:0] r_o_sample;
    logic [FRAC_W-1:0]   r_o_frac;
    logic [SAMPLE_W-1:0] r_o_next;
    logic                r_o_adj;

    logic                w_neg;
    logic [SEED_W-1:0]   w_mag;
    logic [LCG_W-1:0]    w_red;
    logic                w_big;
    logic                w_seed_neg;
    logic [LCG_W-1:0]    w_abs;
    logic [D_W-1:0]      w_d;
    logic                w_last;
    logic [DIV_IN_W-1:0] w_div_in;
    logic [DIV_IN_W-1:0] w_lcg_v;
    logic                w_div_done;
    logic [DIV_Q_W-1:0]  w_q;
    logic [SAMPLE_W-1:0] w_r;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [SAMPLE_W-1:0] w_rdata;

    // sign-keeping reduction of the seed modulo 2^24
    assign w_neg      = r_seed[SEED_W-1];
    assign w_mag      = w_neg ? (SEED_W'(0) - r_seed) : r_seed;
    assign w_red      = w_mag[LCG_W-1:0];
    assign w_big      = |w_mag[SEED_W-1:LCG_W];
    assign w_seed_neg = w_neg && (w_red != '0);
    assign w_abs      = r_cmd ? w_red : r_lcg;

    // |inc - seed|, reduced modulo LCG_MOD by the divider
    always_comb begin
        if (r_cmd && w_seed_neg) begin
            w_d = D_W'(w_abs) + D_W'(LCG_INC);
        end else if (w_abs > LCG_W'(LCG_INC)) begin
            w_d = D_W'(w_abs - LCG_W'(LCG_INC));
        end else begin
            w_d = D_W'(LCG_W'(LCG_INC) - w_abs);
        end
    end

    assign w_last  = (r_cnt == CNT_W'(TABLE_SIZE));
    assign w_lcg_v = DIV_IN_W'(r_lcg) * DIV_IN_W'(LCG_MUL) + DIV_IN_W'(LCG_INC);

    always_comb begin
        case (i_cmd.div_op)
            OP_SEED: w_div_in = DIV_IN_W'(r_d);
            OP_LCG:  w_div_in = w_lcg_v;
            OP_SLOT: w_div_in = DIV_IN_W'(r_sv) * DIV_IN_W'(TABLE_SIZE);
            OP_FRAC: w_div_in = DIV_IN_W'({r_sample, {FRAC_W{1'b0}}});
            default: w_div_in = '0;
        endcase
    end

    slcg_divm u_divm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_value (w_div_in),
        .o_done  (w_div_done),
        .o_quot  (w_q),
        .o_rem   (w_r)
    );

    assign w_we    = (i_cmd.rf_step && !w_last) || i_cmd.draw_commit;
    assign w_waddr = i_cmd.draw_commit ? r_slot : r_cnt[ADDR_W-1:0];

    slcg_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_r),
        .i_re    (i_cmd.tbl_read),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg  <= '0;
            r_sv   <= '0;
            r_init <= 1'b0;
        end else begin
            if (i_cmd.seed_apply && r_cmd && !w_seed_neg) begin
                r_lcg <= w_red;
            end
            if (i_cmd.rf_init || i_cmd.rf_step || i_cmd.draw_commit) begin
                r_lcg <= LCG_W'(w_r);
            end
            if (i_cmd.rf_step && w_last) begin
                r_sv   <= w_r;
                r_init <= 1'b1;
            end
            if (i_cmd.draw_commit) begin
                r_sv <= w_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd  <= i_in_cmd;
            r_seed <= i_seed_value;
        end
        if (i_cmd.seed_apply) begin
            r_d   <= w_d;
            r_adj <= r_cmd && w_big;
        end
        if (i_cmd.rf_init) begin
            r_cnt <= '0;
        end else if (i_cmd.rf_step && !w_last) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.slot_load) begin
            if (w_q >= DIV_Q_W'(TABLE_SIZE)) begin
                r_slot <= ADDR_W'(TABLE_SIZE - 1);
            end else begin
                r_slot <= w_q[ADDR_W-1:0];
            end
        end
        if (i_cmd.draw_commit) begin
            r_sample <= w_rdata;
        end
        if (i_cmd.frac_load) begin
            r_frac <= w_q;
        end
        if (i_cmd.out_load) begin
            r_o_sample <= r_sample;
            r_o_frac   <= r_frac;
            r_o_next   <= r_lcg[SAMPLE_W-1:0];
            r_o_adj    <= r_adj;
        end
    end

    assign o_status.need_refill = (r_cmd && w_seed_neg) || !r_init;
    assign o_status.div_done    = w_div_done;
    assign o_status.rf_last     = w_last;

    assign o_sample        = r_o_sample;
    assign o_fraction      = r_o_frac;
    assign o_next_state    = r_o_next;
    assign o_seed_adjusted = r_o_adj;

endmodule

// ----- rtl/slcg_ctrl.sv -----
module slcg_ctrl import slcg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_push;

    assign w_push = (r_state == ST_PUSH) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SEED;
            end
            ST_SEED: begin
                n_state = i_status.need_refill ? ST_RF_MOD_GO : ST_SLOT_GO;
            end
            ST_RF_MOD_GO: n_state = ST_RF_MOD_WAIT;
            ST_RF_MOD_WAIT: begin
                if (i_status.div_done) n_state = ST_RF_STEP_GO;
            end
            ST_RF_STEP_GO: n_state = ST_RF_STEP_WAIT;
            ST_RF_STEP_WAIT: begin
                if (i_status.div_done) begin
                    n_state = i_status.rf_last ? ST_SLOT_GO : ST_RF_STEP_GO;
                end
            end
            ST_SLOT_GO: n_state = ST_SLOT_WAIT;
            ST_SLOT_WAIT: begin
                if (i_status.div_done) n_state = ST_READ;
            end
            ST_READ: n_state = ST_LCG_WAIT;
            ST_LCG_WAIT: begin
                if (i_status.div_done) n_state = ST_FRAC_GO;
            end
            ST_FRAC_GO: n_state = ST_FRAC_WAIT;
            ST_FRAC_WAIT: begin
                if (i_status.div_done) n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (w_push) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            ST_SEED: o_cmd.seed_apply = 1'b1;
            ST_RF_MOD_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = OP_SEED;
            end
            ST_RF_MOD_WAIT: o_cmd.rf_init = i_status.div_done;
            ST_RF_STEP_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = OP_LCG;
            end
            ST_RF_STEP_WAIT: o_cmd.rf_step = i_status.div_done;
            ST_SLOT_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = OP_SLOT;
            end
            ST_SLOT_WAIT: o_cmd.slot_load = i_status.div_done;
            ST_READ: begin
                o_cmd.tbl_read  = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = OP_LCG;
            end
            ST_LCG_WAIT: o_cmd.draw_commit = i_status.div_done;
            ST_FRAC_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = OP_FRAC;
            end
            ST_FRAC_WAIT: o_cmd.frac_load = i_status.div_done;
            ST_PUSH: o_cmd.out_load = w_push;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        if (w_push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/shuffled_lcg_random_generator.sv -----
// Shuffled linear congruential generator, x' = (1366*x + 150889) mod 714025, behind a
// TABLE_SIZE-entry shuffle table. Each input beat gives one output beat: the drawn sample,
// its Q0.24 fraction of the modulus, the generator state after the draw and a flag that
// the seed was reduced modulo 2^24. cmd = 1 loads seed_value first; a negative reduced
// seed, or the first beat after reset, refills the table. One shared constant divider
// does every mod and quotient, one operation at a time: a plain draw runs three of them,
// and a refill adds TABLE_SIZE + 2 more. One beat is in work at a time; the finished
// output beat waits in its own register, so the next input beat is taken meanwhile.
module shuffled_lcg_random_generator import slcg_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    slcg_in_if.sink   i_in,
    slcg_out_if.source o_out
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    slcg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    slcg_datapath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_in_cmd        (i_in.cmd),
        .i_seed_value    (i_in.seed_value),
        .o_sample        (o_out.sample),
        .o_fraction      (o_out.fraction),
        .o_next_state    (o_out.next_state),
        .o_seed_adjusted (o_out.seed_adjusted)
    );

endmodule

// ----- rtl/slcg_chk.sv -----
module slcg_chk import slcg_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [SAMPLE_W-1:0] i_sample,
    input logic [SAMPLE_W-1:0] i_next_state
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again right after a beat");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared one cycle after accept");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_sample < SAMPLE_W'(LCG_MOD)) && (i_next_state < SAMPLE_W'(LCG_MOD)))
        else $error("output value not below the modulus");

endmodule

bind shuffled_lcg_random_generator slcg_chk u_slcg_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_sample     (o_out.sample),
    .i_next_state (o_out.next_state)
);

// ----- sim/tb.sv -----
module tb;
    import slcg_pkg::*;

    localparam int TBL_SIZE   = TABLE_SIZE_DEF;
    localparam int RAND_ITEMS = 880;
    localparam int LONG_HOLD  = 300;
    localparam int PAUSE_AT   = 600;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic [FRAC_W-1:0]   fraction;
        logic [SAMPLE_W-1:0] next_state;
        logic                seed_adjusted;
    } draw_t;

    class draw_scoreboard;
        longint unsigned lcg_x;
        longint unsigned shuffle_tbl [TBL_SIZE];
        longint unsigned shuffle_val;
        bit              filled;
        draw_t           pending_draws [$];
        int              mismatches;
        int              draws;
        int              loads;
        int              refills;

        function new();
            lcg_x       = 0;
            shuffle_val = 0;
            filled      = 1'b0;
            mismatches  = 0;
            draws       = 0;
            loads       = 0;
            refills     = 0;
            foreach (shuffle_tbl[k]) shuffle_tbl[k] = 0;
        endfunction

        function longint unsigned lcg_advance(longint unsigned x);
            return (64'(LCG_MUL) * (x & 64'hFF_FFFF) + 64'(LCG_INC)) % 64'(LCG_MOD);
        endfunction

        function void refill_table(longint seed);
            longint          v;
            longint unsigned x;
            v = (longint'(LCG_INC) - seed) % longint'(LCG_MOD);
            if (v < 0) v = -v;
            x = v;
            for (int k = 0; k < TBL_SIZE; k++) begin
                x = lcg_advance(x);
                shuffle_tbl[k] = x;
            end
            x           = lcg_advance(x);
            shuffle_val = x;
            lcg_x       = x;
            filled      = 1'b1;
            refills++;
        endfunction

        function void note_request(logic cmd, logic [SEED_W-1:0] seed_raw);
            logic [SEED_W-1:0] mag;
            longint            seed;
            longint unsigned   slot;
            longint unsigned   picked;
            draw_t             d;
            d.seed_adjusted = 1'b0;
            seed = longint'(lcg_x);
            if (cmd) begin
                loads++;
                mag = seed_raw[SEED_W-1] ? -seed_raw : seed_raw;
                d.seed_adjusted = (mag > 32'h00FF_FFFF);
                seed = longint'(mag & 32'h00FF_FFFF);
                if (seed_raw[SEED_W-1]) seed = -seed;
                if (seed >= 0) lcg_x = seed;
            end else begin
                draws++;
            end
            if (seed < 0 || !filled) refill_table(seed);
            slot = (64'(TBL_SIZE) * shuffle_val) / 64'(LCG_MOD);
            if (slot >= TBL_SIZE) slot = TBL_SIZE - 1;
            picked            = shuffle_tbl[slot];
            lcg_x             = lcg_advance(lcg_x);
            shuffle_tbl[slot] = lcg_x;
            shuffle_val       = picked;
            d.sample     = SAMPLE_W'(picked);
            d.fraction   = FRAC_W'((picked << 24) / 64'(LCG_MOD));
            d.next_state = SAMPLE_W'(lcg_x);
            pending_draws.push_back(d);
        endfunction

        function void check_draw(draw_t got);
            draw_t want;
            if (pending_draws.size() == 0) begin
                $error("unexpected beat: sample %0d", got.sample);
                mismatches++;
                return;
            end
            want = pending_draws.pop_front();
            if (got.sample !== want.sample) begin
                $error("sample: expected %0d, got %0d", want.sample, got.sample);
                mismatches++;
            end
            if (got.fraction !== want.fraction) begin
                $error("fraction: expected %0d, got %0d", want.fraction, got.fraction);
                mismatches++;
            end
            if (got.next_state !== want.next_state) begin
                $error("next_state: expected %0d, got %0d", want.next_state, got.next_state);
                mismatches++;
            end
            if (got.seed_adjusted !== want.seed_adjusted) begin
                $error("seed_adjusted: expected %0b, got %0b",
                       want.seed_adjusted, got.seed_adjusted);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    slcg_in_if  in_bus ();
    slcg_out_if out_bus ();

    shuffled_lcg_random_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    draw_scoreboard sb = new();
    int             sent = 0;
    bit             send_quiet = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic issue(input logic cmd, input logic [SEED_W-1:0] seed_raw);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.cmd        <= cmd;
        in_bus.seed_value <= seed_raw;
        do @(posedge i_clk); while (!in_bus.ready);
        sb.note_request(cmd, seed_raw);
        sent++;
        send_quiet = ((sent / 50) % 4) == 3;
    endtask

    // sink side: random stalls, one long hold-off to back up the block
    initial begin
        int    stall;
        int    taken;
        bit    quiet;
        draw_t got;
        taken = 0;
        out_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            quiet = ((taken / 64) % 3) == 2;
            stall = quiet ? 0 : $urandom_range(0, 7);
            if (taken == 300) stall = LONG_HOLD;
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_bus.valid && out_bus.ready));
            got.sample        = out_bus.sample;
            got.fraction      = out_bus.fraction;
            got.next_state    = out_bus.next_state;
            got.seed_adjusted = out_bus.seed_adjusted;
            sb.check_draw(got);
            taken++;
        end
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int r;
        i_rst_n           <= 1'b0;
        in_bus.valid      <= 1'b0;
        in_bus.cmd        <= 1'b0;
        in_bus.seed_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // draw before any load, seed extremes, zero-reducing negatives
        issue(1'b0, 32'hFFFF_FFFF);
        issue(1'b0, 32'h0000_0000);
        issue(1'b1, 32'h0000_0000);
        issue(1'b1, 32'h0000_0001);
        issue(1'b1, 32'h00FF_FFFF);
        issue(1'b1, 32'h0100_0000);
        issue(1'b1, 32'h7FFF_FFFF);
        issue(1'b1, 32'hFFFF_FFFF);
        issue(1'b0, 32'h5555_AAAA);
        issue(1'b1, 32'hFF00_0000);
        issue(1'b1, 32'h8000_0000);
        issue(1'b1, 32'hFF00_0001);
        issue(1'b1, 32'hFE00_0000);
        issue(1'b0, 32'hAAAA_5555);
        issue(1'b0, 32'h0000_0000);
        issue(1'b0, 32'hFFFF_FFFF);
        issue(1'b1, 32'h8000_0001);
        issue(1'b1, 32'h1234_5678);
        issue(1'b0, 32'h0000_0000);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == PAUSE_AT) begin
                in_bus.valid <= 1'b0;
                do @(posedge i_clk); while (sb.pending_draws.size() != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 62)
                issue(1'b0, $urandom());
            else if (r < 74)
                issue(1'b1, $urandom_range(0, 24'hFF_FFFF));
            else if (r < 88)
                issue(1'b1, {1'b0, 31'($urandom())});
            else if (r < 94)
                issue(1'b1, $urandom() | 32'h8000_0000);
            else
                issue(1'b1, -32'($urandom_range(1, 24'hFF_FFFF)));
        end
        in_bus.valid <= 1'b0;

        do @(posedge i_clk); while (sb.pending_draws.size() != 0);
        repeat (40) @(posedge i_clk);

        $display("covered %0d beats: %0d draws, %0d seed loads, %0d table refills",
                 sent, sb.draws, sb.loads, sb.refills);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ----- shuffled_lcg_random_generator.f -----
rtl/slcg_pkg.sv
rtl/slcg_if.sv
rtl/slcg_ram.sv
rtl/slcg_divm.sv
rtl/slcg_datapath.sv
rtl/slcg_ctrl.sv
rtl/shuffled_lcg_random_generator.sv
rtl/slcg_chk.sv
sim/tb.sv
